// File: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/mbrs_pkg.sv
// shared types, codes and constants of the bus master readout sequencer
package mbrs_pkg;

  localparam int FRAME_MAX_DEF = 256;
  localparam int BURST_MAX     = 7;
  localparam int BURST_CNT_W   = $clog2(BURST_MAX + 1);
  localparam int BURST_IDX_W   = $clog2(BURST_MAX);
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  localparam logic [7:0] BYTE_START    = 8'h10;
  localparam logic [7:0] CTRL_SND_NKE  = 8'h40;
  localparam logic [7:0] CTRL_REQ_UD2  = 8'h5b;
  localparam logic [7:0] BYTE_STOP     = 8'h16;
  localparam logic [7:0] BYTE_ACK      = 8'he5;
  localparam logic [7:0] CTRL_FCB      = 8'h20;

  localparam logic [15:0] ACK_TO_RST    = 16'd2000;
  localparam logic [15:0] SETTLE_RST    = 16'd1000;
  localparam logic [15:0] REPLY_TO_RST  = 16'd5000;
  localparam logic [15:0] TICK_MAX      = 16'hffff;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_TICK  = 2'd1,
    ACT_BYTE  = 2'd2
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_STATION  = 2'd0,
    REG_ACK_TO   = 2'd1,
    REG_SETTLE   = 2'd2,
    REG_REPLY_TO = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    KIND_TX     = 2'd0,
    KIND_FWD    = 2'd1,
    KIND_STATUS = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_NONE      = 3'd0,
    ST_ACK_OK    = 3'd1,
    ST_ACK_TO    = 3'd2,
    ST_BAD_ACK   = 3'd3,
    ST_TEL_DONE  = 3'd4,
    ST_REPLY_TO  = 3'd5,
    ST_OVERFLOW  = 3'd6,
    ST_SESS_DONE = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_ACK    = 2'd1,
    PH_SETTLE = 2'd2,
    PH_REPLY  = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic [7:0]  byte_index;
    status_t     status;
  } result_t;

  typedef struct packed {
    logic [BURST_CNT_W-1:0]          cnt;
    result_t [BURST_MAX-1:0]         slot;
  } burst_t;

  typedef struct packed {
    phase_t      phase;
    logic        fcb;
    logic [7:0]  left;
    logic [15:0] timer;
    logic [7:0]  rlen;
  } seq_state_t;

  typedef struct packed {
    logic [7:0]  station;
    logic [15:0] ack_to;
    logic [15:0] settle;
    logic [15:0] reply_to;
  } cfg_t;

  function automatic result_t make_result(kind_t k, logic [7:0] d, logic [7:0] idx,
                                          status_t st);
    result_t r;
    r.kind       = k;
    r.data_byte  = d;
    r.byte_index = idx;
    r.status     = st;
    return r;
  endfunction

  // byte i of a short frame: start, control, address, checksum, stop
  function automatic logic [7:0] frame_byte(logic [7:0] ctrl, logic [7:0] addr,
                                            logic [2:0] i);
    logic [7:0] b;
    case (i)
      3'd0:    b = BYTE_START;
      3'd1:    b = ctrl;
      3'd2:    b = addr;
      3'd3:    b = ctrl + addr;
      3'd4:    b = BYTE_STOP;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: design/mbrs_step.sv
// next sequencer state and result burst for one input word
module mbrs_step #(
  parameter int FRAME_MAX = mbrs_pkg::FRAME_MAX_DEF
) (
  input  logic [1:0]           action,
  input  logic [7:0]           max_telegrams,
  input  logic [7:0]           rx_byte,
  input  mbrs_pkg::seq_state_t st,
  input  mbrs_pkg::cfg_t       cfg,
  output mbrs_pkg::seq_state_t st_nxt,
  output mbrs_pkg::burst_t     burst
);

  localparam logic [8:0] FRAME_LIM = 9'(FRAME_MAX);

  logic        is_start, is_tick, is_byte;
  logic [15:0] tick_inc;
  logic        ack_to, settle_done, reply_to, ack_ok, ack_bad;
  logic        fwd, tel_done, ovf, req, req_go, sess_done;
  logic        fcb_req;
  logic [7:0]  req_ctrl;

  assign is_start = (action == mbrs_pkg::ACT_START);
  assign is_tick  = (action == mbrs_pkg::ACT_TICK);
  assign is_byte  = (action == mbrs_pkg::ACT_BYTE);

  // saturating tick count
  assign tick_inc = (st.timer != mbrs_pkg::TICK_MAX) ? st.timer + 16'd1 : st.timer;

  assign ack_to      = is_tick && (st.phase == mbrs_pkg::PH_ACK) && (tick_inc >= cfg.ack_to);
  assign settle_done = is_tick && (st.phase == mbrs_pkg::PH_SETTLE) &&
                       (tick_inc >= cfg.settle);
  assign reply_to    = is_tick && (st.phase == mbrs_pkg::PH_REPLY) &&
                       (tick_inc >= cfg.reply_to);
  assign ack_ok      = is_byte && (st.phase == mbrs_pkg::PH_ACK) &&
                       (rx_byte == mbrs_pkg::BYTE_ACK);
  assign ack_bad     = is_byte && (st.phase == mbrs_pkg::PH_ACK) &&
                       (rx_byte != mbrs_pkg::BYTE_ACK);
  assign fwd         = is_byte && (st.phase == mbrs_pkg::PH_REPLY);
  assign tel_done    = fwd && (rx_byte == mbrs_pkg::BYTE_STOP);
  assign ovf         = fwd && !tel_done && (({1'b0, st.rlen} + 9'd1) >= FRAME_LIM);
  assign req         = settle_done || (ack_ok && (cfg.settle == 16'd0)) || tel_done;
  assign req_go      = req && (st.left != 8'd0);
  assign sess_done   = req && (st.left == 8'd0);

  // a finished telegram flips the frame count bit before the next request
  assign fcb_req  = tel_done ? ~st.fcb : st.fcb;
  assign req_ctrl = mbrs_pkg::CTRL_REQ_UD2 | (fcb_req ? mbrs_pkg::CTRL_FCB : 8'h00);

  // next state
  always_comb begin
    st_nxt = st;
    if (is_start) begin
      st_nxt.fcb   = 1'b1;
      st_nxt.left  = max_telegrams;
      st_nxt.timer = 16'd0;
      st_nxt.rlen  = 8'd0;
      st_nxt.phase = mbrs_pkg::PH_ACK;
    end else if (is_tick && (st.phase != mbrs_pkg::PH_IDLE)) begin
      st_nxt.timer = tick_inc;
      if (ack_to || reply_to) begin
        st_nxt.phase = mbrs_pkg::PH_IDLE;
      end
    end else if (ack_ok) begin
      st_nxt.timer = 16'd0;
      st_nxt.phase = mbrs_pkg::PH_SETTLE;
    end else if (ack_bad) begin
      st_nxt.phase = mbrs_pkg::PH_IDLE;
    end else if (fwd) begin
      if (tel_done) begin
        st_nxt.fcb = ~st.fcb;
      end else if (ovf) begin
        st_nxt.phase = mbrs_pkg::PH_IDLE;
      end else begin
        st_nxt.rlen = st.rlen + 8'd1;
      end
    end
    if (sess_done) begin
      st_nxt.phase = mbrs_pkg::PH_IDLE;
    end else if (req_go) begin
      st_nxt.left  = st.left - 8'd1;
      st_nxt.rlen  = 8'd0;
      st_nxt.timer = 16'd0;
      st_nxt.phase = mbrs_pkg::PH_REPLY;
    end
  end

  // result words in emit order
  always_comb begin
    logic [mbrs_pkg::BURST_IDX_W-1:0] n;
    logic [7:0]                       fctrl;
    logic                             send;
    n          = '0;
    burst.slot = '0;
    send       = is_start || req_go;
    fctrl      = is_start ? mbrs_pkg::CTRL_SND_NKE : req_ctrl;
    if (ack_to) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_ACK_TO);
      n = n + 3'd1;
    end
    if (reply_to) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_REPLY_TO);
      n = n + 3'd1;
    end
    if (ack_ok) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_ACK_OK);
      n = n + 3'd1;
    end
    if (ack_bad) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_BAD_ACK);
      n = n + 3'd1;
    end
    if (fwd) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_FWD, rx_byte, st.rlen,
                                            mbrs_pkg::ST_NONE);
      n = n + 3'd1;
    end
    if (tel_done) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_TEL_DONE);
      n = n + 3'd1;
    end
    if (ovf) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_OVERFLOW);
      n = n + 3'd1;
    end
    if (sess_done) begin
      burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_STATUS, 8'h00, 8'h00,
                                            mbrs_pkg::ST_SESS_DONE);
      n = n + 3'd1;
    end
    if (send) begin
      for (int i = 0; i < 5; i++) begin
        burst.slot[n] = mbrs_pkg::make_result(mbrs_pkg::KIND_TX,
                          mbrs_pkg::frame_byte(fctrl, cfg.station, 3'(i)), 8'(i),
                          mbrs_pkg::ST_NONE);
        n = n + 3'd1;
      end
    end
    burst.cnt = n;
  end

endmodule

// File: design/mbrs_burst.sv
// result burst register that shifts out one word per cycle while out_stall is low
module mbrs_burst (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  mbrs_pkg::burst_t     load_burst,
  input  logic                 out_stall,
  output mbrs_pkg::result_t    head,
  output logic                 out_valid,
  output logic                 out_last,
  output logic                 room
);

  mbrs_pkg::result_t [mbrs_pkg::BURST_MAX-1:0] slot_r, slot_nxt;
  logic [mbrs_pkg::BURST_CNT_W-1:0]            cnt_r, cnt_nxt;
  logic                                        pop;

  assign out_valid = (cnt_r != '0);
  assign out_last  = (cnt_r == mbrs_pkg::BURST_CNT_W'(1));
  assign pop       = out_valid && !out_stall;
  // empty, or the final word leaves in this cycle
  assign room      = (cnt_r == '0) || (out_last && !out_stall);
  assign head      = slot_r[0];

  always_comb begin
    slot_nxt = slot_r;
    cnt_nxt  = cnt_r;
    if (load) begin
      slot_nxt = load_burst.slot;
      cnt_nxt  = load_burst.cnt;
    end else if (pop) begin
      for (int i = 0; i < mbrs_pkg::BURST_MAX - 1; i++) begin
        slot_nxt[i] = slot_r[i+1];
      end
      cnt_nxt = cnt_r - mbrs_pkg::BURST_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r <= slot_nxt;
  end

endmodule

// File: design/mbus_master_readout_sequencer.sv
// top level of the bus master readout sequencer (reset frame, ack, data requests)
// Takes one input word (start, millisecond tick or received byte) and answers with
// zero to seven result words: transmit bytes of the SND_NKE and REQ_UD2 short frames,
// forwarded reply bytes and status events, the last one flagged by out_last. The
// sequencer state is updated at the accepting edge and the whole burst for that word
// is built in one pass into a seven-entry burst register, which releases one result
// word per cycle while out_stall is low. A new input word is accepted when that
// register is empty or in the cycle its final word is taken, so a new word waits
// until the whole burst of the previous one has drained. Configuration (station
// address and the three tick limits) is written through cfg_we/cfg_index/cfg_wdata;
// the user must write it only while the block is idle; the block does not enforce this.
module mbus_master_readout_sequencer #(
  parameter int FRAME_MAX = mbrs_pkg::FRAME_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_action,
  input  logic [7:0]                       in_max_telegrams,
  input  logic [7:0]                       in_rx_byte,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [1:0]                       out_kind,
  output logic [7:0]                       out_data_byte,
  output logic [7:0]                       out_byte_index,
  output logic [2:0]                       out_status,
  output logic                             out_last,
  // configuration writes
  input  logic                             cfg_we,
  input  logic [mbrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mbrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  mbrs_pkg::seq_state_t st_r, st_nxt;
  mbrs_pkg::cfg_t       cfg_r, cfg_nxt;
  mbrs_pkg::burst_t     burst;
  mbrs_pkg::result_t    head;
  logic                 room;
  logic                 in_fire;

  assign in_stall = !room;
  assign in_fire  = in_valid && room;

  // decode and burst build
  mbrs_step #(
    .FRAME_MAX (FRAME_MAX)
  ) u_step (
    .action        (in_action),
    .max_telegrams (in_max_telegrams),
    .rx_byte       (in_rx_byte),
    .st            (st_r),
    .cfg           (cfg_r),
    .st_nxt        (st_nxt),
    .burst         (burst)
  );

  // output side: burst register drained one word per cycle while out_stall is low
  mbrs_burst u_burst (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .load_burst (burst),
    .out_stall  (out_stall),
    .head       (head),
    .out_valid  (out_valid),
    .out_last   (out_last),
    .room       (room)
  );

  assign out_kind       = head.kind;
  assign out_data_byte  = head.data_byte;
  assign out_byte_index = head.byte_index;
  assign out_status     = head.status;

  // sequencer state only moves when an input word is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.phase <= mbrs_pkg::PH_IDLE;
      st_r.fcb   <= 1'b0;
      st_r.left  <= 8'd0;
      st_r.timer <= 16'd0;
      st_r.rlen  <= 8'd0;
    end else if (in_fire) begin
      st_r <= st_nxt;
    end
  end

  // register writes, narrower registers keep the low bits
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        mbrs_pkg::REG_STATION:  cfg_nxt.station  = cfg_wdata[7:0];
        mbrs_pkg::REG_ACK_TO:   cfg_nxt.ack_to   = cfg_wdata;
        mbrs_pkg::REG_SETTLE:   cfg_nxt.settle   = cfg_wdata;
        mbrs_pkg::REG_REPLY_TO: cfg_nxt.reply_to = cfg_wdata;
        default:                cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.station  <= 8'd0;
      cfg_r.ack_to   <= mbrs_pkg::ACK_TO_RST;
      cfg_r.settle   <= mbrs_pkg::SETTLE_RST;
      cfg_r.reply_to <= mbrs_pkg::REPLY_TO_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/mbrs_checker.sv
// port-level assertion checker for the readout sequencer and its bind
`include "assert_macros.svh"

module mbrs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic [1:0]                       in_action,
  input logic [7:0]                       in_max_telegrams,
  input logic [7:0]                       in_rx_byte,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic [1:0]                       out_kind,
  input logic [7:0]                       out_data_byte,
  input logic [7:0]                       out_byte_index,
  input logic [2:0]                       out_status,
  input logic                             out_last,
  input logic                             cfg_we,
  input logic [mbrs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input logic [mbrs_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  // a stalled result word stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid, "result word dropped while stalled")

  // a start word always opens with the frame start byte in the next cycle
  `ASSERT_NEXT(a_start_frame, clk, rst_n, in_valid && !in_stall && (in_action == mbrs_pkg::ACT_START), out_valid && (out_kind == mbrs_pkg::KIND_TX) && (out_data_byte == mbrs_pkg::BYTE_START) && (out_byte_index == 8'h00), "start did not begin a short frame")

  // a burst is not broken before its last word
  `ASSERT_NEXT(a_burst_cont, clk, rst_n, out_valid && !out_stall && !out_last, out_valid, "result burst ended without last")

  // input only waits on pending results
  `ASSERT_SAME(a_stall_cause, clk, rst_n, in_stall, out_valid, "input stalled with no pending result")

  // status words carry a real code and no byte payload
  `ASSERT_SAME(a_status_word, clk, rst_n, out_valid && (out_kind == mbrs_pkg::KIND_STATUS), (out_status != mbrs_pkg::ST_NONE) && (out_data_byte == 8'h00) && (out_byte_index == 8'h00), "malformed status word")

endmodule

bind mbus_master_readout_sequencer mbrs_checker u_mbrs_checker (.*);

// File: dv/testbench.sv
// self-checking testbench for the bus master readout sequencer
`timescale 1ns / 100ps

// The sender walks a short directed script, then drives random readout sessions
// that are steered by the predicted sequencer phase. Most of these are well-formed:
// start, acknowledge, settle ticks, reply telegrams closed by the stop byte. The
// rest is noise: stray ticks, bad acknowledges, early restarts and the unused
// action code. Every accepted input word runs through a local predictor, which
// queues the result words it expects. The receiver compares each accepted result
// word against the oldest queued one.
module testbench;
  import mbrs_pkg::*;

  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         REPLY_MAX    = FRAME_MAX_DEF;
  localparam int         RANDOM_WORDS = 330;  // random words offered, long reply included
  localparam int         QUIET_FROM   = 300;  // no idling on either side from here on
  localparam int         PHASE_LEN    = 20;   // random words per register setting
  localparam int         LONG_FROM    = 40;   // the full-length reply starts after this
  localparam int         DRAIN_CYCLES = 10;   // extra wait after the last expected word
  localparam int         LONG_HOLD    = 120;  // long receiver hold-off, fills the block
  localparam int         CYCLE_LIMIT  = 400000;

  // one expected result word
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data_byte;
    logic [7:0] byte_index;
    status_t    status;
    logic       last;
  } out_word_t;

  // one row of the directed script: an input word, or a full register setting
  typedef struct {
    bit          setup;
    logic [1:0]  action;
    logic [7:0]  max_tel;
    logic [7:0]  rx;
    status_t     typed;     // ST_NONE: the predictor supplies the expected words
    logic [7:0]  station;
    logic [15:0] ack_to;
    logic [15:0] settle;
    logic [15:0] reply_to;
  } script_row_t;

  logic        clk              = 1'b0;
  logic        rst_n            = 1'b0;
  logic        in_valid         = 1'b0;
  logic        in_stall;
  logic [1:0]  in_action        = ACT_START;
  logic [7:0]  in_max_telegrams = 8'h00;
  logic [7:0]  in_rx_byte       = 8'h00;
  logic        out_valid;
  logic        out_stall        = 1'b0;
  logic [1:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic [7:0]  out_byte_index;
  logic [2:0]  out_status;
  logic        out_last;
  logic        cfg_we           = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_STATION;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  mbus_master_readout_sequencer dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_action        (in_action),
    .in_max_telegrams (in_max_telegrams),
    .in_rx_byte       (in_rx_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_data_byte    (out_data_byte),
    .out_byte_index   (out_byte_index),
    .out_status       (out_status),
    .out_last         (out_last),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor: register copies and sequencer state, the state updated per accepted word
  // ---------------------------------------------------------------------------
  logic [7:0]  addr_reg     = 8'h00;
  logic [15:0] ack_limit    = ACK_TO_RST;
  logic [15:0] settle_limit = SETTLE_RST;
  logic [15:0] reply_limit  = REPLY_TO_RST;

  phase_t      seq_phase    = PH_IDLE;
  logic        fcb          = 1'b0;
  logic [7:0]  tel_left     = 8'h00;
  logic [15:0] tick_count   = 16'h0000;
  logic [7:0]  reply_len    = 8'h00;

  out_word_t   word_batch[$];     // words caused by the word being predicted
  out_word_t   pending_words[$];  // expected words not yet seen on the output

  function automatic void emit(kind_t k, logic [7:0] d, logic [7:0] idx, status_t st);
    word_batch.push_back('{kind: k, data_byte: d, byte_index: idx, status: st, last: 1'b0});
  endfunction

  // short frame: start, control, address, checksum, stop
  function automatic void send_frame(logic [7:0] ctrl);
    emit(KIND_TX, BYTE_START, 8'd0, ST_NONE);
    emit(KIND_TX, ctrl, 8'd1, ST_NONE);
    emit(KIND_TX, addr_reg, 8'd2, ST_NONE);
    emit(KIND_TX, ctrl + addr_reg, 8'd3, ST_NONE);
    emit(KIND_TX, BYTE_STOP, 8'd4, ST_NONE);
  endfunction

  // next data request, or the end of the session once no request is left
  function automatic void next_request();
    if (tel_left == 8'h00) begin
      emit(KIND_STATUS, 8'h00, 8'h00, ST_SESS_DONE);
      seq_phase = PH_IDLE;
    end else begin
      tel_left = tel_left - 8'd1;
      send_frame(CTRL_REQ_UD2 | (fcb ? CTRL_FCB : 8'h00));
      reply_len  = 8'h00;
      tick_count = 16'h0000;
      seq_phase  = PH_REPLY;
    end
  endfunction

  // tick counter saturates at its top value
  function automatic logic [15:0] bump_ticks();
    if (tick_count != TICK_MAX)
      tick_count = tick_count + 16'd1;
    return tick_count;
  endfunction

  // returns 0 when the sequencer ignores the word
  function automatic bit sequence_step(logic [1:0] act, logic [7:0] mt, logic [7:0] rb);
    bit         acted;
    logic [7:0] idx;
    word_batch.delete();
    acted = 1'b1;
    case (act)
      ACT_START: begin
        // also abandons a running session
        fcb        = 1'b1;
        tel_left   = mt;
        tick_count = 16'h0000;
        reply_len  = 8'h00;
        send_frame(CTRL_SND_NKE);
        seq_phase  = PH_ACK;
      end
      ACT_TICK: begin
        case (seq_phase)
          PH_ACK: begin
            if (bump_ticks() >= ack_limit) begin
              emit(KIND_STATUS, 8'h00, 8'h00, ST_ACK_TO);
              seq_phase = PH_IDLE;
            end
          end
          PH_SETTLE: begin
            if (bump_ticks() >= settle_limit)
              next_request();
          end
          PH_REPLY: begin
            if (bump_ticks() >= reply_limit) begin
              emit(KIND_STATUS, 8'h00, 8'h00, ST_REPLY_TO);
              seq_phase = PH_IDLE;
            end
          end
          default: acted = 1'b0;
        endcase
      end
      ACT_BYTE: begin
        case (seq_phase)
          PH_ACK: begin
            if (rb == BYTE_ACK) begin
              emit(KIND_STATUS, 8'h00, 8'h00, ST_ACK_OK);
              tick_count = 16'h0000;
              seq_phase  = PH_SETTLE;
              // no settle time: first request goes out with the ack event
              if (settle_limit == 16'h0000)
                next_request();
            end else begin
              emit(KIND_STATUS, 8'h00, 8'h00, ST_BAD_ACK);
              seq_phase = PH_IDLE;
            end
          end
          PH_REPLY: begin
            idx = reply_len;
            emit(KIND_FWD, rb, idx, ST_NONE);
            if (rb == BYTE_STOP) begin
              fcb = ~fcb;
              emit(KIND_STATUS, 8'h00, 8'h00, ST_TEL_DONE);
              next_request();
            end else if (int'(idx) + 1 >= REPLY_MAX) begin
              // reply buffer full without a stop byte
              emit(KIND_STATUS, 8'h00, 8'h00, ST_OVERFLOW);
              seq_phase = PH_IDLE;
            end else begin
              reply_len = idx + 8'd1;
            end
          end
          default: acted = 1'b0;  // idle or settling
        endcase
      end
      default: acted = 1'b0;      // unused action code
    endcase
    if (word_batch.size() != 0)
      word_batch[word_batch.size() - 1].last = 1'b1;
    return acted;
  endfunction

  // ---------------------------------------------------------------------------
  // bookkeeping shared by the sender and the receiver
  // ---------------------------------------------------------------------------
  int cycle_count  = 0;
  int errors       = 0;
  int words_sent   = 0;
  int results_seen = 0;
  int settings     = 0;
  int status_count[8];
  bit quiet        = 1'b0;  // last part of the run: no idling anywhere
  bit hold_req     = 1'b0;  // sender asks for the long receiver hold-off

  always @(posedge clk)
    cycle_count <= cycle_count + 1;

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one input word and hold it until accepted, then predict its results
  task automatic offer(logic [1:0] act, logic [7:0] mt, logic [7:0] rb, status_t typed,
                       output bit acted);
    int gap;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_action        <= act;
    in_max_telegrams <= mt;
    in_rx_byte       <= rb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    acted = sequence_step(act, mt, rb);
    if (typed == ST_NONE) begin
      foreach (word_batch[i]) pending_words.push_back(word_batch[i]);
    end else begin
      // status word typed in by hand, predictor only kept in step
      pending_words.push_back('{kind: KIND_STATUS, data_byte: 8'h00, byte_index: 8'h00,
                                status: typed, last: 1'b1});
    end
    words_sent++;
  endtask

  // sender pauses until every expected word is out and the block has settled
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write all four registers, one per cycle, while the block is idle
  task automatic load_settings(logic [7:0] station, logic [15:0] ack_to,
                               logic [15:0] settle, logic [15:0] reply_to);
    reg_idx_t    idx[4];
    logic [15:0] val[4];
    idx = '{REG_STATION, REG_ACK_TO, REG_SETTLE, REG_REPLY_TO};
    val = '{{8'h00, station}, ack_to, settle, reply_to};
    for (int i = 0; i < 4; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we       <= 1'b0;
    addr_reg     = station;
    ack_limit    = ack_to;
    settle_limit = settle;
    reply_limit  = reply_to;
    settings++;
  endtask

  function automatic script_row_t item_st(logic [1:0] act, logic [7:0] mt, logic [7:0] rb,
                                          status_t st);
    script_row_t row;
    row = '{setup: 1'b0, action: act, max_tel: mt, rx: rb, typed: st,
            station: 8'h00, ack_to: 16'h0000, settle: 16'h0000, reply_to: 16'h0000};
    return row;
  endfunction

  function automatic script_row_t item(logic [1:0] act, logic [7:0] mt, logic [7:0] rb);
    return item_st(act, mt, rb, ST_NONE);
  endfunction

  function automatic script_row_t setup(logic [7:0] station, logic [15:0] ack_to,
                                        logic [15:0] settle, logic [15:0] reply_to);
    script_row_t row;
    row = item(ACT_START, 8'h00, 8'h00);
    row.setup    = 1'b1;
    row.station  = station;
    row.ack_to   = ack_to;
    row.settle   = settle;
    row.reply_to = reply_to;
    return row;
  endfunction

  // tick limit for a random setting: mostly small, sometimes an extreme
  function automatic logic [15:0] pick_limit(int lo, int hi);
    int r;
    r = $urandom_range(0, 9);
    if (r == 0)
      return 16'h0000;
    else if (r == 1)
      return 16'hffff;
    else
      return 16'($urandom_range(lo, hi));
  endfunction

  initial begin
    script_row_t script[$];
    logic [1:0]  act;
    logic [7:0]  mt;
    logic [7:0]  rb;
    bit          acted;
    bit          long_reply;
    bit          overflow_done;
    int          r;
    int          random_words;
    int          phase_items;
    int          wait_left;

    // directed script; zero tick limits time out on the first tick
    script.push_back(setup(8'hff, 16'h0000, 16'h0000, 16'h0000));
    script.push_back(item(ACT_UNUSED, 8'hff, 8'hff));              // unused code, ignored
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_ACK));             // byte while idle
    script.push_back(item(ACT_TICK, 8'h00, 8'h00));                // tick while idle
    script.push_back(item(ACT_START, 8'h02, 8'h00));               // reset frame
    script.push_back(item_st(ACT_TICK, 8'h00, 8'h00, ST_ACK_TO));
    script.push_back(item(ACT_START, 8'h00, 8'h00));
    script.push_back(item_st(ACT_BYTE, 8'h00, 8'h00, ST_BAD_ACK));
    script.push_back(item(ACT_START, 8'h00, 8'h00));               // no requests allowed
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_ACK));             // ack ok, session done
    script.push_back(item(ACT_START, 8'hff, 8'h00));
    script.push_back(item(ACT_START, 8'h02, 8'hff));               // restart while busy
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_ACK));             // ack ok plus request
    script.push_back(item(ACT_BYTE, 8'h00, 8'h68));
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_STOP));            // seven result words
    script.push_back(item_st(ACT_TICK, 8'h00, 8'h00, ST_REPLY_TO));
    script.push_back(setup(8'h00, 16'hffff, 16'd2, 16'hffff));
    script.push_back(item(ACT_START, 8'h01, 8'h00));
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_ACK));
    script.push_back(item(ACT_BYTE, 8'h00, 8'h55));                // byte while settling
    script.push_back(item(ACT_TICK, 8'h00, 8'h00));
    script.push_back(item(ACT_TICK, 8'h00, 8'h00));                // settle over, request
    script.push_back(item(ACT_BYTE, 8'h00, 8'hff));
    script.push_back(item(ACT_TICK, 8'h00, 8'h00));
    script.push_back(item(ACT_BYTE, 8'h00, BYTE_STOP));            // last telegram of session

    long_reply    = 1'b0;
    overflow_done = 1'b0;
    random_words  = 0;
    phase_items   = PHASE_LEN;  // forces a fresh setting before the first random word

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) begin
      if (script[i].setup) begin
        drain();
        load_settings(script[i].station, script[i].ack_to, script[i].settle,
                      script[i].reply_to);
      end else begin
        offer(script[i].action, script[i].max_tel, script[i].rx, script[i].typed, acted);
      end
    end

    // random sessions, steered by the predicted phase
    while (random_words < RANDOM_WORDS || long_reply) begin
      if (phase_items >= PHASE_LEN && !long_reply) begin
        // wind the session down so the registers can change
        if (seq_phase == PH_ACK) begin
          offer(ACT_BYTE, 8'h00, 8'h00, ST_NONE, acted);
        end else if (seq_phase != PH_IDLE) begin
          offer(ACT_START, 8'h00, 8'h00, ST_NONE, acted);
        end else begin
          drain();
          case (settings)
            2: load_settings(8'hff, 16'hffff, 16'h0000, 16'hffff);
            3: load_settings(8'h00, 16'h0001, 16'hffff, 16'h0001);
            default: load_settings(8'($urandom_range(0, 255)), pick_limit(1, 6),
                                   pick_limit(0, 4), pick_limit(2, 16));
          endcase
          phase_items = 0;
          // long hold-off while the sender keeps offering words
          if (settings == 4) hold_req = 1'b1;
        end
      end else begin
        r  = $urandom_range(0, 99);
        act = ACT_BYTE;
        mt = 8'($urandom_range(0, 255));
        rb = 8'($urandom_range(0, 255));
        case (seq_phase)
          PH_IDLE: begin
            if (r < 85)      act = ACT_START;
            else if (r < 92) act = ACT_TICK;
            else if (r < 97) act = ACT_BYTE;
            else             act = ACT_UNUSED;
          end
          PH_ACK: begin
            if (r < 80)      rb = BYTE_ACK;
            else if (r < 88) act = ACT_BYTE;
            else if (r < 97) act = ACT_TICK;
            else             act = ACT_UNUSED;
          end
          PH_SETTLE: begin
            if (r < 80)      act = ACT_TICK;
            else if (r < 92) act = ACT_BYTE;
            else if (r < 96) act = ACT_UNUSED;
            else             act = ACT_START;
          end
          default: begin
            // one full-length reply without a stop byte, early in the run
            if (!overflow_done && random_words >= LONG_FROM && reply_len == 8'h00) begin
              long_reply    = 1'b1;
              overflow_done = 1'b1;
            end
            if (long_reply) begin
              if (rb == BYTE_STOP) rb = 8'h00;
            end else if (r < 3)  act = ACT_START;
            else if (r < 10) act = ACT_TICK;
            else if (r < 12) act = ACT_UNUSED;
            else if (r < 24) rb = BYTE_STOP;
          end
        endcase
        if (act == ACT_START) begin
          r = $urandom_range(0, 9);
          if (r < 7)      mt = 8'($urandom_range(0, 3));
          else if (r < 9) mt = 8'($urandom_range(4, 10));
        end
        offer(act, mt, rb, ST_NONE, acted);
        random_words++;
        if (acted && !long_reply) phase_items++;
        if (seq_phase != PH_REPLY) long_reply = 1'b0;
        quiet = (random_words >= QUIET_FROM);
      end
    end

    // all stimulus accepted: wait for the remaining result words
    in_valid <= 1'b0;
    wait_left = 5000;
    while (pending_words.size() != 0 && wait_left > 0) begin
      @(posedge clk);
      wait_left--;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_words.size() != 0) begin
      $error("%0d expected result words never arrived", pending_words.size());
      errors++;
    end

    $display("run: %0d input words (%0d random), %0d result words, %0d register settings",
             words_sent, random_words, results_seen, settings);
    $display("events: ack ok %0d, ack timeout %0d, bad ack %0d, telegram %0d, reply timeout %0d, overflow %0d, session end %0d",
             status_count[ST_ACK_OK], status_count[ST_ACK_TO], status_count[ST_BAD_ACK],
             status_count[ST_TEL_DONE], status_count[ST_REPLY_TO],
             status_count[ST_OVERFLOW], status_count[ST_SESS_DONE]);
    if (errors == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: checks each accepted word, then picks next cycle's stall
  // ---------------------------------------------------------------------------
  int hold_left  = 0;
  int stall_left = 0;
  bit hold_done  = 1'b0;

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_words.size() == 0) begin
        $error("unexpected result word: kind %0d data %02h index %0d status %0d",
               out_kind, out_data_byte, out_byte_index, out_status);
        errors++;
      end else begin
        want = pending_words.pop_front();
        if (want.kind == KIND_STATUS) status_count[want.status]++;
        if (out_kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, out_kind);
          errors++;
        end
        if (out_data_byte !== want.data_byte) begin
          $error("data_byte: expected %02h, actual %02h", want.data_byte, out_data_byte);
          errors++;
        end
        if (out_byte_index !== want.byte_index) begin
          $error("byte_index: expected %0d, actual %0d", want.byte_index, out_byte_index);
          errors++;
        end
        if (out_status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, out_status);
          errors++;
        end
        if (out_last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, out_last);
          errors++;
        end
      end
    end

    // long hold-off once, counted here; random bursts otherwise
    if (hold_req && !hold_done) begin
      hold_left = LONG_HOLD;
      hold_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 7) - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // hang guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d result words outstanding",
             cycle_count, pending_words.size());
    $display("testbench failed");
    $finish;
  end

endmodule
